FILE: rtl/core/ssie_pkg.sv
`default_nettype none
package ssie_pkg;

    // sequencer phases, one-hot
    typedef enum logic [15:0] {
        PH_IDLE      = 16'h0001,
        PH_PRE_W1    = 16'h0002,
        PH_PRE_LOW1  = 16'h0004,
        PH_PRE_W2    = 16'h0008,
        PH_PRE_HIGH2 = 16'h0010,
        PH_PRE_W3    = 16'h0020,
        PH_PRE_LOW2  = 16'h0040,
        PH_POLL      = 16'h0080,
        PH_LEAD_HIGH = 16'h0100,
        PH_LEAD_W    = 16'h0200,
        PH_BIT_LOW   = 16'h0400,
        PH_LOW_W     = 16'h0800,
        PH_SAMPLE    = 16'h1000,
        PH_SAMP_W    = 16'h2000,
        PH_BIT_HIGH  = 16'h4000,
        PH_HIGH_W    = 16'h8000
    } t_phase;

    // configuration register indexes
    localparam logic [7:0] CFG_PREAMBLE_DELAY   = 8'd0;
    localparam logic [7:0] CFG_BIT_DELAY        = 8'd1;
    localparam logic [7:0] CFG_FRAME_BITS       = 8'd2;
    localparam logic [7:0] CFG_START_POLL_LIMIT = 8'd3;

    localparam logic [15:0] RST_PREAMBLE_DELAY   = 16'd2;
    localparam logic [15:0] RST_BIT_DELAY        = 16'd0;
    localparam logic [5:0]  RST_FRAME_BITS       = 6'd19;
    localparam logic [7:0]  RST_START_POLL_LIMIT = 8'd100;

    typedef struct packed {
        logic [15:0] preamble_delay;
        logic [15:0] bit_delay;
        logic [5:0]  frame_bits;
        logic [7:0]  start_poll_limit;
    } t_cfg;

    // sequencer control state (shift word travels separately, its width is a parameter)
    typedef struct packed {
        t_phase      phase;
        logic [15:0] wait_count;
        logic [7:0]  poll_count;
        logic [5:0]  bits_left;
        logic        clock_level;
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/core/ssie_step.sv
`default_nettype none
// One tick of the read sequencer: current state plus one input word in,
// next state and done flag out.
module ssie_step #(
    parameter int WORD_BITS = 32
) (
    input  wire ssie_pkg::t_state  i_state,
    input  wire [WORD_BITS-1:0]    i_shift,
    input  wire ssie_pkg::t_cfg    i_cfg,
    input  wire                    i_start,
    input  wire                    i_data,
    output ssie_pkg::t_state       o_state,
    output logic [WORD_BITS-1:0]   o_shift,
    output logic                   o_done
);

    logic [15:0] w_wait_dec;
    logic [7:0]  w_poll_inc;
    logic [5:0]  w_bits_dec;

    assign w_wait_dec = (i_state.wait_count != 16'd0) ? i_state.wait_count - 16'd1
                                                       : i_state.wait_count;
    assign w_poll_inc = i_state.poll_count + 8'd1;
    assign w_bits_dec = (i_state.bits_left != 6'd0) ? i_state.bits_left - 6'd1
                                                     : i_state.bits_left;

    always_comb begin
        o_state = i_state;
        o_shift = i_shift;
        o_done  = 1'b0;
        unique case (i_state.phase)
            ssie_pkg::PH_IDLE: begin
                if (i_start) begin
                    o_state.clock_level = 1'b1;
                    o_shift             = '0;
                    o_state.poll_count  = 8'd0;
                    o_state.bits_left   = (i_cfg.frame_bits == 6'd0) ? 6'd1 : i_cfg.frame_bits;
                    if (i_cfg.preamble_delay == 16'd0) begin
                        o_state.phase = ssie_pkg::PH_PRE_LOW1;
                    end else begin
                        o_state.phase      = ssie_pkg::PH_PRE_W1;
                        o_state.wait_count = i_cfg.preamble_delay;
                    end
                end
            end
            ssie_pkg::PH_PRE_W1, ssie_pkg::PH_PRE_W2, ssie_pkg::PH_PRE_W3,
            ssie_pkg::PH_LEAD_W, ssie_pkg::PH_LOW_W, ssie_pkg::PH_SAMP_W,
            ssie_pkg::PH_HIGH_W: begin
                o_state.wait_count = w_wait_dec;
                if (w_wait_dec == 16'd0) begin
                    unique case (i_state.phase)
                        ssie_pkg::PH_PRE_W1: o_state.phase = ssie_pkg::PH_PRE_LOW1;
                        ssie_pkg::PH_PRE_W2: o_state.phase = ssie_pkg::PH_PRE_HIGH2;
                        ssie_pkg::PH_PRE_W3: o_state.phase = ssie_pkg::PH_PRE_LOW2;
                        ssie_pkg::PH_LEAD_W: o_state.phase = ssie_pkg::PH_BIT_LOW;
                        ssie_pkg::PH_LOW_W:  o_state.phase = ssie_pkg::PH_SAMPLE;
                        ssie_pkg::PH_SAMP_W: o_state.phase = ssie_pkg::PH_BIT_HIGH;
                        default: begin
                            if (i_state.bits_left == 6'd0) begin
                                o_state.phase = ssie_pkg::PH_IDLE;
                                o_done        = 1'b1;
                            end else begin
                                o_state.phase = ssie_pkg::PH_BIT_LOW;
                            end
                        end
                    endcase
                end
            end
            ssie_pkg::PH_PRE_LOW1: begin
                o_state.clock_level = 1'b0;
                if (i_cfg.preamble_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_PRE_HIGH2;
                end else begin
                    o_state.phase      = ssie_pkg::PH_PRE_W2;
                    o_state.wait_count = i_cfg.preamble_delay;
                end
            end
            ssie_pkg::PH_PRE_HIGH2: begin
                o_state.clock_level = 1'b1;
                if (i_cfg.preamble_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_PRE_LOW2;
                end else begin
                    o_state.phase      = ssie_pkg::PH_PRE_W3;
                    o_state.wait_count = i_cfg.preamble_delay;
                end
            end
            ssie_pkg::PH_PRE_LOW2: begin
                o_state.clock_level = 1'b0;
                o_state.poll_count  = 8'd0;
                o_state.phase = (i_cfg.start_poll_limit == 8'd0) ? ssie_pkg::PH_LEAD_HIGH
                                                                 : ssie_pkg::PH_POLL;
            end
            ssie_pkg::PH_POLL: begin
                o_state.poll_count = w_poll_inc;
                // start bit seen, limit hit, or counter wrapped
                if (!i_data || w_poll_inc >= i_cfg.start_poll_limit || w_poll_inc == 8'd0) begin
                    o_state.phase = ssie_pkg::PH_LEAD_HIGH;
                end
            end
            ssie_pkg::PH_LEAD_HIGH: begin
                o_state.clock_level = 1'b1;
                if (i_cfg.preamble_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_BIT_LOW;
                end else begin
                    o_state.phase      = ssie_pkg::PH_LEAD_W;
                    o_state.wait_count = i_cfg.preamble_delay;
                end
            end
            ssie_pkg::PH_BIT_LOW: begin
                o_state.clock_level = 1'b0;
                if (i_cfg.bit_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_SAMPLE;
                end else begin
                    o_state.phase      = ssie_pkg::PH_LOW_W;
                    o_state.wait_count = i_cfg.bit_delay;
                end
            end
            ssie_pkg::PH_SAMPLE: begin
                o_shift = {i_shift[WORD_BITS-2:0], i_data};
                if (i_cfg.bit_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_BIT_HIGH;
                end else begin
                    o_state.phase      = ssie_pkg::PH_SAMP_W;
                    o_state.wait_count = i_cfg.bit_delay;
                end
            end
            ssie_pkg::PH_BIT_HIGH: begin
                o_state.clock_level = 1'b1;
                o_state.bits_left   = w_bits_dec;
                if (w_bits_dec == 6'd0 && i_cfg.bit_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_IDLE;
                    o_done        = 1'b1;
                end else if (i_cfg.bit_delay == 16'd0) begin
                    o_state.phase = ssie_pkg::PH_BIT_LOW;
                end else begin
                    o_state.phase      = ssie_pkg::PH_HIGH_W;
                    o_state.wait_count = i_cfg.bit_delay;
                end
            end
            default: begin
                o_state.phase = ssie_pkg::PH_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/ssi_encoder_read_master_unit.sv
// SSI absolute encoder read master, one input word per serial-line tick.
// Path: an accepted input word passes through the input register, then the
// result register; both hold while the output side stalls.
// Throughput: one word per cycle unless the output side stalls; the tick step is a single pass of logic.
// Reset (synchronous, active low): sequencer idle, sequencer clock level high,
// registers back to their defaults, both word registers empty.
`default_nettype none
module ssi_encoder_read_master_unit #(
    parameter int WORD_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // tick words in
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_start_req,
    input  wire         i_data_in,
    // result words out
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_clock_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [31:0] o_position,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown
    // indexes are dropped.
    // ---------------------------------------------------------------
    ssie_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preamble_delay   <= ssie_pkg::RST_PREAMBLE_DELAY;
            r_cfg.bit_delay        <= ssie_pkg::RST_BIT_DELAY;
            r_cfg.frame_bits       <= ssie_pkg::RST_FRAME_BITS;
            r_cfg.start_poll_limit <= ssie_pkg::RST_START_POLL_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ssie_pkg::CFG_PREAMBLE_DELAY:   r_cfg.preamble_delay   <= i_cfg_data;
                ssie_pkg::CFG_BIT_DELAY:        r_cfg.bit_delay        <= i_cfg_data;
                ssie_pkg::CFG_FRAME_BITS:       r_cfg.frame_bits       <= i_cfg_data[5:0];
                ssie_pkg::CFG_START_POLL_LIMIT: r_cfg.start_poll_limit <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register. It advances whenever the result register is
    // empty or being drained, so a word enters every cycle unless the
    // output side stalls.
    // ---------------------------------------------------------------
    logic r_in_valid;
    logic r_in_start;
    logic r_in_data;
    logic w_adv;

    assign w_adv      = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_start <= i_start_req;
            r_in_data  <= i_data_in;
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state, updated once per processed tick word.
    // ---------------------------------------------------------------
    ssie_pkg::t_state       r_state;
    ssie_pkg::t_state       n_state;
    logic [WORD_BITS-1:0]   r_shift;
    logic [WORD_BITS-1:0]   n_shift;
    logic                   w_done;
    logic [63:0]            w_shift_ext;

    ssie_step #(
        .WORD_BITS (WORD_BITS)
    ) u_step (
        .i_state (r_state),
        .i_shift (r_shift),
        .i_cfg   (r_cfg),
        .i_start (r_in_start),
        .i_data  (r_in_data),
        .o_state (n_state),
        .o_shift (n_shift),
        .o_done  (w_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= ssie_pkg::PH_IDLE;
            r_state.wait_count  <= 16'd0;
            r_state.poll_count  <= 8'd0;
            r_state.bits_left   <= 6'd0;
            r_state.clock_level <= 1'b1;    // clock idles high
            r_shift             <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
            r_shift <= n_shift;
        end
    end

    // position shows the low 32 bits of the shift word, zero-extended if narrower
    assign w_shift_ext = 64'(n_shift);

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_clock_out <= n_state.clock_level;
            o_busy_res  <= (n_state.phase != ssie_pkg::PH_IDLE);
            o_done_res  <= w_done;
            o_position  <= w_done ? w_shift_ext[31:0] : 32'd0;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ssie_checker.sv
`default_nettype none
module ssie_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_clock_out,
    input wire        o_busy_res,
    input wire        o_done_res,
    input wire [31:0] o_position
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_position) && $stable(o_done_res)
             && $stable(o_busy_res) && $stable(o_clock_out)))
        else $error("result word changed while stalled");

    // done tick: no longer busy and clock back high
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (!o_busy_res && o_clock_out))
        else $error("done without idle state");

    // position only on the done tick
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_position == 32'd0))
        else $error("position nonzero outside done");

    // clock line idles high
    a_idle_clk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> o_clock_out)
        else $error("clock low while idle");

endmodule

bind ssi_encoder_read_master_unit ssie_checker u_ssie_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_clock_out (o_clock_out),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_position  (o_position)
);
`default_nettype wire
